// File: rtl/sli_pkg.sv
// shared constants, types and codes for the sorted insertion list
package sli_pkg;

	// list geometry
	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int CNTF_W  = 5;
	localparam int ODATA_W = ((VAL_W + CNTF_W + 7) / 8) * 8;
	localparam int OPAD_W  = ODATA_W - VAL_W - CNTF_W;

	typedef logic signed [VAL_W-1:0] value_t;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2
	} mode_t;

	// result status carried on the output tuser
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	// operation broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		value_t   value;
	} cell_cmd_t;

	// control sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

endpackage

// File: rtl/sorted_list_insert_delete.sv
// sorted insertion list: a chain of compare/shift cells plus a result sequencer
// insert and delete: the request is compared in every cell at once and the chain shifts
// as the request is taken; the result appears in the output register next cycle
// a dump takes the request, then loads one word per cycle from the chain while the receiver is
// not stalling, count words (one empty-status word if empty); no request is taken until its last word is loaded
// reset (arst_n low, asynchronous) empties the list and drops any pending output word
module sorted_list_insert_delete (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sli_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value
	input  logic [1:0]                   s_tuser,   // [1:0] mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sli_pkg::ODATA_W-1:0]  m_tdata,   // [31:0] value_out, [36:32] count, zero pad
	output logic [1:0]                   m_tuser,   // [1:0] status
	output logic                         m_tlast
);
	import sli_pkg::*;

	// cell row signals
	value_t    cell_value [DEPTH];
	logic      cell_valid [DEPTH];
	logic      cell_lt    [DEPTH];
	logic      cell_eq    [DEPTH];
	logic [DEPTH-1:0] valid_vec;
	logic [DEPTH-1:0] eq_vec;
	cell_cmd_t cmd;

	// control state
	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [IDX_W-1:0] ptr_q;

	// output register
	logic             out_valid_q;
	value_t           out_value_q;
	status_t          out_status_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_last_q;

	// next output word
	logic             load_out;
	value_t           nxt_value;
	status_t          nxt_status;
	logic [CNT_W-1:0] nxt_count;
	logic             nxt_last;

	logic  accept;
	logic  out_free;
	logic  full;
	logic  found;
	logic  dump_end;
	mode_t mode;

	// the cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t lv;
		logic   lvl;
		logic   llt;
		value_t rv;
		logic   rvl;
		if (i == 0) begin : g_first
			assign lv  = cmd.value;
			assign lvl = 1'b1;
			assign llt = 1'b1;
		end else begin : g_mid
			assign lv  = cell_value[i-1];
			assign lvl = cell_valid[i-1];
			assign llt = cell_lt[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rv  = cell_value[i];
			assign rvl = 1'b0;
		end else begin : g_body
			assign rv  = cell_value[i+1];
			assign rvl = cell_valid[i+1];
		end
		sli_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_value  (lv),
			.left_valid  (lvl),
			.left_lt     (llt),
			.right_value (rv),
			.right_valid (rvl),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.lt          (cell_lt[i]),
			.eq          (cell_eq[i])
		);
		assign valid_vec[i] = cell_valid[i];
		assign eq_vec[i]    = cell_eq[i];
	end

	// handshake and list status
	assign mode     = mode_t'(s_tuser);
	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	// entries are sorted, so any matching entry means the first not-smaller one matches
	assign found    = |eq_vec;
	assign dump_end = (CNT_W'(ptr_q) == count_q - CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_DUMP && count_q != '0) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (out_free && dump_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: cell command, count update and next output word
	always_comb begin
		s_tready   = 1'b0;
		cmd.op     = CELL_HOLD;
		cmd.value  = value_t'(s_tdata);
		count_d    = count_q;
		load_out   = 1'b0;
		nxt_value  = value_t'(s_tdata);
		nxt_status = STAT_OK;
		nxt_count  = count_q;
		nxt_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (accept) begin
					case (mode)
						MODE_INSERT: begin
							load_out = 1'b1;
							if (full) begin
								nxt_status = STAT_FULL;
							end else begin
								cmd.op    = CELL_INSERT;
								count_d   = count_q + CNT_W'(1);
								nxt_count = count_d;
							end
						end
						MODE_DELETE: begin
							load_out = 1'b1;
							if (found) begin
								cmd.op    = CELL_DELETE;
								count_d   = count_q - CNT_W'(1);
								nxt_count = count_d;
							end else begin
								nxt_status = STAT_NOT_FOUND;
							end
						end
						MODE_DUMP: begin
							if (count_q == '0) begin
								load_out   = 1'b1;
								nxt_value  = '0;
								nxt_status = STAT_EMPTY;
							end
						end
						default: begin
							load_out = 1'b0;
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					load_out  = 1'b1;
					nxt_value = cell_value[ptr_q];
					nxt_last  = dump_end;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_IDLE) begin
				ptr_q <= '0;
			end else if (out_free) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q  <= nxt_value;
			out_status_q <= nxt_status;
			out_count_q  <= nxt_count;
			out_last_q   <= nxt_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {OPAD_W'(0), CNTF_W'(out_count_q), out_value_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// occupied cells always form a prefix whose length is the count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("cell occupancy disagrees with count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count exceeds depth");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> (count_q != '0 && CNT_W'(ptr_q) < count_q))
		else $error("dump pointer outside held entries");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_INSERT && !full) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_dump_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> !s_tready)
		else $error("request taken during dump");

endmodule

// File: rtl/sli_cell.sv
// one storage cell of the sorted chain with its compare and shift logic
module sli_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sli_pkg::cell_cmd_t cmd,
	input  sli_pkg::value_t    left_value,
	input  logic               left_valid,
	input  logic               left_lt,
	input  sli_pkg::value_t    right_value,
	input  logic               right_valid,
	output sli_pkg::value_t    value,
	output logic               valid,
	output logic               lt,
	output logic               eq
);
	import sli_pkg::*;

	value_t value_q;
	value_t value_d;
	logic   valid_q;
	logic   valid_d;

	// compare against the broadcast request value
	assign lt    = valid_q && (value_q < cmd.value);
	assign eq    = valid_q && (value_q == cmd.value);
	assign value = value_q;
	assign valid = valid_q;

	// cells at or past the insert/delete point shift toward a neighbor
	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		case (cmd.op)
			CELL_INSERT: begin
				if (!lt) begin
					value_d = left_lt ? cmd.value : left_value;
					valid_d = left_valid;
				end
			end
			CELL_DELETE: begin
				if (!lt) begin
					value_d = right_value;
					valid_d = right_valid;
				end
			end
			default: begin
				value_d = value_q;
				valid_d = valid_q;
			end
		endcase
	end

	// payload register
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

endmodule

// File: tb/tb_sorted_list_insert_delete.sv
// self-checking testbench for the sorted insertion list
module tb_sorted_list_insert_delete;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	// the fourth mode code is unused and must be ignored by the block
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int PRINT_CAP   = 40;

	typedef struct {
		value_t              value;
		status_t             status;
		logic [CNTF_W-1:0]   count;
		logic                last;
	} list_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VAL_W-1:0]    s_tdata  = '0;
	logic [1:0]          s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [ODATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	// predicted list contents and the words still owed by the block
	value_t        held_q[$];
	list_result_t  list_results[$];
	list_result_t  want_word;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;

	sorted_list_insert_delete dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, list_results.size());
			$display("tb_sorted_list_insert_delete: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (err_count < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, what);
		err_count++;
	endtask

	// queue one expected word; count is taken after the operation
	function automatic void owe_word(input value_t v, input status_t st, input logic lst);
		list_result_t w;
		w.value  = v;
		w.status = st;
		w.count  = CNTF_W'(held_q.size());
		w.last   = lst;
		list_results.push_back(w);
	endfunction

	// list behavior for one accepted request word
	function automatic void predict_list_op(input logic [1:0] mode, input value_t v);
		int pos;
		pos = 0;
		case (mode)
			MODE_INSERT: begin
				if (held_q.size() >= DEPTH) begin
					owe_word(v, STAT_FULL, 1'b1);
				end else begin
					// new value goes ahead of the first entry not smaller
					while (pos < held_q.size() && held_q[pos] < v)
						pos++;
					held_q.insert(pos, v);
					owe_word(v, STAT_OK, 1'b1);
				end
			end
			MODE_DELETE: begin
				while (pos < held_q.size() && held_q[pos] < v)
					pos++;
				if (pos < held_q.size() && held_q[pos] == v) begin
					held_q.delete(pos);
					owe_word(v, STAT_OK, 1'b1);
				end else begin
					owe_word(v, STAT_NOT_FOUND, 1'b1);
				end
			end
			MODE_DUMP: begin
				if (held_q.size() == 0) begin
					owe_word('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < held_q.size(); i++)
						owe_word(held_q[i], STAT_OK, i == held_q.size() - 1);
				end
			end
			default: begin
				// unused mode: no state change, no words
			end
		endcase
	endfunction

	// send one request word; entered and left at a falling edge with tvalid still up
	task automatic send_word(input logic [1:0] mode, input value_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_list_op(mode, v);
		@(negedge clk);
	endtask

	// hold off the sender until every owed word has come back
	task automatic wait_list_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (list_results.size() != 0)
			@(negedge clk);
	endtask

	// value mix: small values for duplicates and hits, extremes, full range
	function automatic value_t pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return value_t'(int'($urandom_range(16)) - 8);
		if (roll < 55) begin
			case ($urandom_range(3))
				0:       return {1'b1, {(VAL_W-1){1'b0}}};
				1:       return {1'b0, {(VAL_W-1){1'b1}}};
				2:       return '1;
				default: return '0;
			endcase
		end
		return value_t'($urandom());
	endfunction

	// receiver stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (list_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word value %0d status %0d",
					$signed(m_tdata[VAL_W-1:0]), m_tuser));
			end else begin
				want_word = list_results.pop_front();
				if (m_tdata[VAL_W-1:0] !== want_word.value)
					report_mismatch($sformatf("value_out %0d, expected %0d",
						$signed(m_tdata[VAL_W-1:0]), want_word.value));
				if (m_tdata[VAL_W +: CNTF_W] !== want_word.count)
					report_mismatch($sformatf("count %0d, expected %0d",
						m_tdata[VAL_W +: CNTF_W], want_word.count));
				if (m_tuser !== want_word.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						m_tuser, want_word.status));
				if (m_tlast !== want_word.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						m_tlast, want_word.last));
			end
		end
	end

	// dump and delete on an empty list, unused mode ignored
	task automatic test_empty_list();
		send_word(MODE_DUMP, value_t'($urandom()));
		send_word(MODE_DELETE, 32'sd5);
		send_word(MODE_UNUSED, value_t'($urandom()));
	endtask

	// signed ordering at the extremes, duplicates, hit and miss deletes
	task automatic test_extremes_and_duplicates();
		send_word(MODE_INSERT, {1'b0, {(VAL_W-1){1'b1}}});
		send_word(MODE_INSERT, {1'b1, {(VAL_W-1){1'b0}}});
		send_word(MODE_INSERT, '1);
		send_word(MODE_INSERT, {1'b1, {(VAL_W-1){1'b0}}});
		send_word(MODE_INSERT, '0);
		send_word(MODE_DUMP, '0);
		send_word(MODE_DELETE, {1'b1, {(VAL_W-1){1'b0}}});
		send_word(MODE_DELETE, 32'sd3);
		send_word(MODE_DUMP, '1);
	endtask

	// fill up, insert into the full list, full dump, then make room again
	task automatic test_full_list();
		while (held_q.size() < DEPTH)
			send_word(MODE_INSERT, value_t'($urandom()));
		send_word(MODE_INSERT, 32'sh5A5A_A5A5);
		send_word(MODE_DUMP, '0);
		send_word(MODE_DELETE, held_q[DEPTH/2]);
		wait_list_idle();
	endtask

	// random traffic with a given mix of inserts and deletes
	task automatic run_random_mix(input int n, input int insert_pct, input int delete_pct);
		int roll;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < insert_pct)
				send_word(MODE_INSERT, pick_value());
			else if (roll < insert_pct + delete_pct) begin
				if (held_q.size() != 0 && $urandom_range(99) < 70)
					send_word(MODE_DELETE, held_q[$urandom_range(held_q.size() - 1)]);
				else
					send_word(MODE_DELETE, pick_value());
			end else if (roll < 97)
				send_word(MODE_DUMP, value_t'($urandom()));
			else
				send_word(MODE_UNUSED, value_t'($urandom()));
		end
	endtask

	// four idling phases, each drained before the next
	task automatic test_random_traffic();
		send_idle_pct = 0;  recv_stall_pct = 0;
		run_random_mix(46, 55, 30);
		wait_list_idle();
		send_idle_pct = 48; recv_stall_pct = 0;
		run_random_mix(46, 70, 15);
		wait_list_idle();
		send_idle_pct = 0;  recv_stall_pct = 48;
		run_random_mix(46, 30, 55);
		wait_list_idle();
		send_idle_pct = 31; recv_stall_pct = 31;
		run_random_mix(45, 45, 35);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_list();
		test_extremes_and_duplicates();
		test_full_list();
		test_random_traffic();

		wait_list_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0) begin
			$display("tb_sorted_list_insert_delete: done, clean");
		end else begin
			$display("tb_sorted_list_insert_delete: done, errors");
		end
		$finish;
	end

endmodule

// File: sorted_list_insert_delete.f
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_delete.sv
tb/tb_sorted_list_insert_delete.sv
